@@ design/three_voice_saturating_sample_mixer_core_defines.svh @@
// Assertion helpers used by the mixer back end (tvsm_back).
`ifndef THREE_VOICE_SATURATING_SAMPLE_MIXER_CORE_DEFINES_SVH
`define THREE_VOICE_SATURATING_SAMPLE_MIXER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TVSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TVSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tvsm_pkg.sv @@
`timescale 1ns / 1ps
package tvsm_pkg;

  typedef struct packed {
    logic [2:0]          func;
    logic signed [15:0]  in_left;
    logic signed [15:0]  in_right;
    logic [23:0]         duration;
    logic [1:0]          clip_select;
    logic [12:0]         clip_address;
    logic signed [15:0]  clip_left;
    logic signed [15:0]  clip_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               button_busy;
    logic               slide_busy;
    logic               hold_busy;
  } out_item_t;

  localparam logic [2:0] FUNC_MIX     = 3'd0;
  localparam logic [2:0] FUNC_TRIG_B  = 3'd1;
  localparam logic [2:0] FUNC_TRIG_S  = 3'd2;
  localparam logic [2:0] FUNC_START   = 3'd3;
  localparam logic [2:0] FUNC_STOP    = 3'd4;
  localparam logic [2:0] FUNC_WRITE   = 3'd5;

  localparam logic [1:0] SEL_BUTTON = 2'd0;
  localparam logic [1:0] SEL_SLIDE  = 2'd1;
  localparam logic [1:0] SEL_HOLD   = 2'd2;

  localparam logic [1:0] CFG_BUTTON_LEN = 2'd0;
  localparam logic [1:0] CFG_SLIDE_LEN  = 2'd1;
  localparam logic [1:0] CFG_HOLD_LEN   = 2'd2;

  localparam int LEN_W     = 14;
  localparam int FRAC_W    = 12;
  localparam int PHASE_W   = 27;
  localparam int STEP_W    = 26;
  localparam int DIV_STEPS = 26;
  localparam int QDEPTH    = 2;
  localparam logic [STEP_W-1:0] UNIT_STEP = 26'h1000;
  localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
  localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

  typedef enum logic [2:0] {
    OP_MIX, OP_TRIG_B, OP_TRIG_S, OP_START, OP_STOP, OP_WRITE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         sel;
    logic [12:0]        addr;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [23:0]        dur;
  } qentry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_MUL, ST_OUT, ST_DIV
  } bstate_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > SAMPLE_MAX) return 16'sh7FFF;
    if (v < SAMPLE_MIN) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

@@ design/tvsm_front.sv @@
`timescale 1ns / 1ps
module tvsm_front #(
  parameter int CLIP_DEPTH = 8192
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  tvsm_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output tvsm_pkg::qentry_t  q_entry
);
  import tvsm_pkg::*;

  localparam logic [16:0] DEPTH_L = 17'(CLIP_DEPTH);

  logic keep;

  assign in_stall = q_full;

  always_comb begin
    keep              = 1'b1;
    q_entry.op        = OP_MIX;
    q_entry.sel       = in_data.clip_select;
    q_entry.addr      = in_data.clip_address;
    q_entry.left      = in_data.in_left;
    q_entry.right     = in_data.in_right;
    q_entry.dur       = in_data.duration;
    unique case (in_data.func)
      FUNC_MIX:    q_entry.op = OP_MIX;
      FUNC_TRIG_B: q_entry.op = OP_TRIG_B;
      FUNC_TRIG_S: q_entry.op = OP_TRIG_S;
      FUNC_START: begin
        q_entry.op = OP_START;
        keep = (in_data.duration != '0);
      end
      FUNC_STOP:   q_entry.op = OP_STOP;
      FUNC_WRITE: begin
        q_entry.op    = OP_WRITE;
        q_entry.left  = in_data.clip_left;
        q_entry.right = in_data.clip_right;
        keep = (in_data.clip_select != 2'd3) && (17'(in_data.clip_address) < DEPTH_L);
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

@@ design/tvsm_queue.sv @@
`timescale 1ns / 1ps
module tvsm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tvsm_pkg::qentry_t push_entry,
  input  logic              pop,
  output tvsm_pkg::qentry_t head,
  output logic              full,
  output logic              empty
);
  import tvsm_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  qentry_t        slots [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == CW'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

@@ design/tvsm_back.sv @@
`timescale 1ns / 1ps
`include "three_voice_saturating_sample_mixer_core_defines.svh"
module tvsm_back #(
  parameter int CLIP_DEPTH = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tvsm_pkg::qentry_t   head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output tvsm_pkg::out_item_t out_data
);
  import tvsm_pkg::*;

  localparam int AW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int LW = 17;
  localparam logic [LW-1:0] DEPTH_L = LW'(CLIP_DEPTH);

  logic [31:0] bmem [CLIP_DEPTH];
  logic [31:0] smem [CLIP_DEPTH];
  logic [31:0] hmem [CLIP_DEPTH];
  logic [31:0] b_q, s_q, h_q;

  bstate_t state_r, state_nxt;

  logic [LEN_W-1:0]   b_len_r, s_len_r, h_len_r;
  logic [LEN_W-1:0]   b_pos_r, s_pos_r;
  logic               b_on_r, s_on_r, h_on_r;
  logic [PHASE_W-1:0] h_phase_r;
  logic [STEP_W-1:0]  h_step_r;

  logic [AW-1:0]      b_addr_r, s_addr_r, ha_addr_r, hb_addr_r, h_raddr, waddr;
  logic [FRAC_W-1:0]  frac_r;
  logic               b_add_r, s_add_r, h_add_r;
  logic signed [15:0] mix_l_r, mix_r_r, sum_l_r, sum_r_r, ha_l_r, ha_r_r;
  logic signed [29:0] prod_l_r, prod_r_r;
  logic [2:0]         busy_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [4:0]         div_cnt_r;
  logic [25:0]        div_num_r, div_q_r;
  logic [23:0]        div_rem_r, div_den_r;

  function automatic logic [LW-1:0] eff_len(input logic [LEN_W-1:0] r);
    return (LW'(r) < DEPTH_L) ? LW'(r) : DEPTH_L;
  endfunction

  logic [LW-1:0]      b_len, s_len, h_len, h_idx, h_nxt, h_idx1;
  logic               b_go, s_go, h_go;
  logic [LEN_W-1:0]   b_pos_nxt, s_pos_nxt;
  logic [24:0]        div_sh;
  logic               div_ge;
  logic               do_mix, do_write, out_free;

  always_comb begin
    b_len     = eff_len(b_len_r);
    s_len     = eff_len(s_len_r);
    h_len     = eff_len(h_len_r);
    b_go      = b_on_r && (LW'(b_pos_r) < b_len);
    s_go      = s_on_r && (LW'(s_pos_r) < s_len);
    b_pos_nxt = b_go ? b_pos_r + 1'b1 : b_pos_r;
    s_pos_nxt = s_go ? s_pos_r + 1'b1 : s_pos_r;
    h_idx     = LW'(h_phase_r[PHASE_W-1:FRAC_W]);
    h_idx1    = h_idx + 1'b1;
    h_go      = h_on_r && (h_idx < h_len);
    h_nxt     = (h_idx1 < h_len) ? h_idx1 : h_idx;
    div_sh    = {div_rem_r, div_num_r[25]};
    div_ge    = div_sh >= 25'(div_den_r);
    out_free  = !out_valid_r || !out_stall;
  end

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign do_mix   = q_pop && head.op == OP_MIX;
  assign do_write = q_pop && head.op == OP_WRITE;
  assign waddr    = AW'(LW'(head.addr));
  assign h_raddr  = (state_r == ST_RDB) ? hb_addr_r : ha_addr_r;

  always_ff @(posedge clk) begin
    if (do_write && head.sel == SEL_BUTTON) bmem[waddr] <= {head.right, head.left};
    b_q <= bmem[b_addr_r];
  end

  always_ff @(posedge clk) begin
    if (do_write && head.sel == SEL_SLIDE) smem[waddr] <= {head.right, head.left};
    s_q <= smem[s_addr_r];
  end

  always_ff @(posedge clk) begin
    if (do_write && head.sel == SEL_HOLD) hmem[waddr] <= {head.right, head.left};
    h_q <= hmem[h_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (head.op == OP_MIX) state_nxt = ST_RDA;
          else if (head.op == OP_START && h_len != '0) state_nxt = ST_DIV;
        end
      end
      ST_RDA: state_nxt = ST_RDB;
      ST_RDB: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_OUT;
      ST_OUT: if (out_free) state_nxt = ST_IDLE;
      ST_DIV: if (div_cnt_r == 5'd1) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_len_r     <= '0;
      s_len_r     <= '0;
      h_len_r     <= '0;
      b_pos_r     <= '0;
      s_pos_r     <= '0;
      b_on_r      <= 1'b0;
      s_on_r      <= 1'b0;
      h_on_r      <= 1'b0;
      h_phase_r   <= '0;
      h_step_r    <= UNIT_STEP;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUTTON_LEN: b_len_r <= cfg_wdata;
          CFG_SLIDE_LEN:  s_len_r <= cfg_wdata;
          CFG_HOLD_LEN:   h_len_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (q_pop) begin
        unique case (head.op)
          OP_MIX: begin
            b_pos_r <= b_pos_nxt;
            s_pos_r <= s_pos_nxt;
            b_on_r  <= b_on_r && (LW'(b_pos_nxt) < b_len);
            s_on_r  <= s_on_r && (LW'(s_pos_nxt) < s_len);
            h_on_r  <= h_go;
            if (h_go) h_phase_r <= h_phase_r + PHASE_W'(h_step_r);
          end
          OP_TRIG_B: begin
            b_pos_r <= '0;
            b_on_r  <= 1'b1;
          end
          OP_TRIG_S: begin
            s_pos_r <= '0;
            s_on_r  <= 1'b1;
          end
          OP_START: div_cnt_r <= 5'(DIV_STEPS);
          OP_STOP:  h_on_r <= 1'b0;
          default: ;
        endcase
      end
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r - 1'b1;
        if (div_cnt_r == 5'd1) begin
          h_step_r  <= {div_q_r[24:0], div_ge};
          h_phase_r <= '0;
          h_on_r    <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (do_mix) begin
      b_addr_r  <= AW'(LW'(b_pos_r));
      s_addr_r  <= AW'(LW'(s_pos_r));
      ha_addr_r <= AW'(h_idx);
      hb_addr_r <= AW'(h_nxt);
      frac_r    <= h_phase_r[FRAC_W-1:0];
      b_add_r   <= b_go;
      s_add_r   <= s_go;
      h_add_r   <= h_go;
      mix_l_r   <= head.left;
      mix_r_r   <= head.right;
      busy_r    <= {b_on_r && (LW'(b_pos_nxt) < b_len),
                    s_on_r && (LW'(s_pos_nxt) < s_len), h_go};
    end
    if (q_pop && head.op == OP_START) begin
      div_num_r <= {h_len[13:0], 12'b0};
      div_den_r <= head.dur;
      div_rem_r <= '0;
      div_q_r   <= '0;
    end else if (state_r == ST_DIV) begin
      div_rem_r <= div_ge ? 24'(div_sh - 25'(div_den_r)) : div_sh[23:0];
      div_num_r <= {div_num_r[24:0], 1'b0};
      div_q_r   <= {div_q_r[24:0], div_ge};
    end
    if (state_r == ST_RDB) begin
      sum_l_r <= sat16(18'(sat16(18'(mix_l_r) + (b_add_r ? 18'(signed'(b_q[15:0])) : 18'sd0)))
                 + (s_add_r ? 18'(signed'(s_q[15:0])) : 18'sd0));
      sum_r_r <= sat16(18'(sat16(18'(mix_r_r) + (b_add_r ? 18'(signed'(b_q[31:16])) : 18'sd0)))
                 + (s_add_r ? 18'(signed'(s_q[31:16])) : 18'sd0));
      ha_l_r  <= signed'(h_q[15:0]);
      ha_r_r  <= signed'(h_q[31:16]);
    end
    if (state_r == ST_MUL) begin
      prod_l_r <= 30'((17'(signed'(h_q[15:0])) - 17'(ha_l_r)) * $signed({1'b0, frac_r}));
      prod_r_r <= 30'((17'(signed'(h_q[31:16])) - 17'(ha_r_r)) * $signed({1'b0, frac_r}));
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r.out_left  <= sat16(18'(sum_l_r) + (h_add_r ?
                              18'(ha_l_r) + 18'(prod_l_r >>> FRAC_W) : 18'sd0));
      out_data_r.out_right <= sat16(18'(sum_r_r) + (h_add_r ?
                              18'(ha_r_r) + 18'(prod_r_r >>> FRAC_W) : 18'sd0));
      out_data_r.button_busy <= busy_r[2];
      out_data_r.slide_busy  <= busy_r[1];
      out_data_r.hold_busy   <= busy_r[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TVSM_ASSERT_IMP(a_pop_idle, q_pop, state_r == ST_IDLE, "pop outside idle")
  `TVSM_ASSERT_NXT(a_out_wait, state_r == ST_OUT && !out_free, state_r == ST_OUT, "result overrun")
  `TVSM_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(state_r) == ST_OUT, "result without mix")
  `TVSM_ASSERT_IMP(a_div_cnt, state_r == ST_DIV, div_cnt_r != '0, "divider count lost")

endmodule

@@ design/three_voice_saturating_sample_mixer_core.sv @@
`timescale 1ns / 1ps
// Three-voice stereo mixer core.
// Input channel (in_valid/in_stall/in_data) takes one command per transfer:
// mix frame, trigger button, trigger slide, start hold, stop hold, write clip.
// Only a mix frame gives a result on out_valid/out_stall/out_data: the
// saturated stereo sum and the three voice busy flags after that frame.
// Commands pass a two-entry queue into a sequencer that owns the clip
// memories, so input transfers continue while a result waits.
// Sequencer path per command: mix passes states RDA, RDB, MUL and OUT (two
// hold reads on one memory port, one multiply stage, saturating adds in RDB
// and OUT); start hold runs a one-bit-per-cycle restoring divider for the
// step; all others finish in the idle state.
// A stalled result holds the sequencer in its output stage; the queue then
// fills and in_stall rises.
// cfg_we writes a clip length register (index 0 button, 1 slide, 2 hold);
// the user must use it only while the core is idle; the core does not enforce this.
// Synchronous reset (rst_n low) empties the queue, stops all voices and sets
// unit hold speed; clip memory contents are not cleared.
module three_voice_saturating_sample_mixer_core #(
  parameter int CLIP_DEPTH = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tvsm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tvsm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_wdata
);
  import tvsm_pkg::*;

  qentry_t push_entry, head;
  logic    push, pop, full, empty;

  tvsm_front #(.CLIP_DEPTH(CLIP_DEPTH)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  tvsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  tvsm_back #(.CLIP_DEPTH(CLIP_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (empty),
    .q_pop     (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/three_voice_saturating_sample_mixer_core_test.sv @@
`timescale 1ns / 1ps
module three_voice_saturating_sample_mixer_core_test;
  import tvsm_pkg::*;

  localparam int DEPTH = 8192;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BUTTON_LEN;
  logic [13:0] cfg_wdata = '0;

  three_voice_saturating_sample_mixer_core #(.CLIP_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // mixer state as predicted
  logic [31:0] clip_mem [3][DEPTH];
  bit          clip_ok [3][DEPTH];
  logic [13:0] len_reg [3] = '{default: '0};
  int unsigned voice_pos [2] = '{0, 0};
  bit          voice_on [3] = '{0, 0, 0};
  logic [26:0] hold_phase = '0;
  logic [25:0] hold_step = UNIT_STEP;

  in_item_t  pending [$];
  out_item_t mix_expect [$];
  out_item_t want;
  int        errors = 0;
  bit        calm = 1'b0;
  bit        in_fire = 1'b0;
  int        in_gap = 0;
  int        stall_left = 0;

  function automatic int eff(int i);
    return (len_reg[i] < DEPTH) ? int'(len_reg[i]) : DEPTH;
  endfunction

  function automatic int sat(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int lane(logic [31:0] w, bit hi);
    logic signed [15:0] s;
    s = hi ? w[31:16] : w[15:0];
    return int'(s);
  endfunction

  function automatic int interp(int a, int b, int frac);
    int s;
    s = a * (4096 - frac) + b * frac;
    return s >>> 12;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t rand_item(logic [2:0] f);
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.func = f;
    return it;
  endfunction

  task automatic model_item(in_item_t it);
    int l, r, idx, nxt, frac, len;
    logic [31:0] wa, wb;
    out_item_t o;
    case (it.func)
      FUNC_TRIG_B: begin
        voice_pos[0] = 0;
        voice_on[0] = 1;
      end
      FUNC_TRIG_S: begin
        voice_pos[1] = 0;
        voice_on[1] = 1;
      end
      FUNC_START: begin
        len = eff(2);
        if (it.duration != 0 && len != 0) begin
          hold_step = 26'((64'(len) << 12) / it.duration);
          hold_phase = '0;
          voice_on[2] = 1;
        end
      end
      FUNC_STOP: voice_on[2] = 0;
      FUNC_WRITE: begin
        if (it.clip_select <= SEL_HOLD) begin
          clip_mem[it.clip_select][it.clip_address] = {it.clip_right, it.clip_left};
          clip_ok[it.clip_select][it.clip_address] = 1;
        end
      end
      FUNC_MIX: begin
        l = int'(it.in_left);
        r = int'(it.in_right);
        for (int v = 0; v < 2; v++) begin
          if (voice_on[v]) begin
            len = eff(v);
            if (voice_pos[v] < len) begin
              wa = clip_mem[v][voice_pos[v]];
              l = sat(l + lane(wa, 0));
              r = sat(r + lane(wa, 1));
              voice_pos[v] = (voice_pos[v] + 1) & 14'h3FFF;
            end
            if (voice_pos[v] >= len) voice_on[v] = 0;
          end
        end
        if (voice_on[2]) begin
          len = eff(2);
          idx = int'(hold_phase >> 12);
          if (idx >= len) begin
            voice_on[2] = 0;
          end else begin
            nxt = (idx + 1 < len) ? idx + 1 : idx;
            frac = int'(hold_phase[11:0]);
            wa = clip_mem[2][idx];
            wb = clip_mem[2][nxt];
            l = sat(l + interp(lane(wa, 0), lane(wb, 0), frac));
            r = sat(r + interp(lane(wa, 1), lane(wb, 1), frac));
            hold_phase = hold_phase + 27'(hold_step);
          end
        end
        o.out_left = l[15:0];
        o.out_right = r[15:0];
        o.button_busy = voice_on[0];
        o.slide_busy = voice_on[1];
        o.hold_busy = voice_on[2];
        mix_expect.push_back(o);
      end
      default: ;
    endcase
  endtask

  task automatic send(in_item_t it);
    model_item(it);
    pending.push_back(it);
  endtask

  task automatic wr_clip(int sel, int addr, int l, int r);
    in_item_t w;
    w = rand_item(FUNC_WRITE);
    w.clip_select = 2'(sel);
    w.clip_address = 13'(addr);
    w.clip_left = 16'(l);
    w.clip_right = 16'(r);
    send(w);
  endtask

  // never let a mix read a clip entry that was not written
  task automatic fill(int sel, int addr);
    if (!clip_ok[sel][addr]) wr_clip(sel, addr, $urandom, $urandom);
  endtask

  task automatic queue_item(in_item_t it);
    int idx;
    if (it.func == FUNC_MIX) begin
      for (int v = 0; v < 2; v++)
        if (voice_on[v] && voice_pos[v] < eff(v)) fill(v, voice_pos[v]);
      if (voice_on[2]) begin
        idx = int'(hold_phase >> 12);
        if (idx < eff(2)) begin
          fill(2, idx);
          fill(2, (idx + 1 < eff(2)) ? idx + 1 : idx);
        end
      end
    end
    send(it);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [13:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    len_reg[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || mix_expect.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic mix(int l, int r);
    in_item_t it;
    it = rand_item(FUNC_MIX);
    it.in_left = 16'(l);
    it.in_right = 16'(r);
    queue_item(it);
  endtask

  task automatic start(int dur);
    in_item_t it;
    it = rand_item(FUNC_START);
    it.duration = 24'(dur);
    queue_item(it);
  endtask

  task automatic random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      it = rand_item(FUNC_MIX);
      if ($urandom_range(0, 6) == 0) it.in_left = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      if ($urandom_range(0, 6) == 0) it.in_right = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end else if (r < 68) begin
      it = rand_item(FUNC_TRIG_B);
    end else if (r < 76) begin
      it = rand_item(FUNC_TRIG_S);
    end else if (r < 84) begin
      it = rand_item(FUNC_START);
      case ($urandom_range(0, 9))
        0: it.duration = '0;
        1: it.duration = 24'd1;
        2: ;
        default: it.duration = 24'($urandom_range(1, 4 * eff(2) + 8));
      endcase
    end else if (r < 87) begin
      it = rand_item(FUNC_STOP);
    end else if (r < 98) begin
      it = rand_item(FUNC_WRITE);
      if ($urandom_range(0, 3) != 0) it.clip_address = 13'($urandom_range(0, 40));
    end else begin
      it = rand_item(FUNC_WRITE);
      it.func = 3'($urandom_range(FUNC_WRITE + 1, 7));
    end
    queue_item(it);
  endtask

  always @(posedge clk) in_fire <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (in_gap > 0 || pending.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        in_data <= pending.pop_front();
        in_valid <= 1'b1;
        in_gap = gap_len();
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (mix_expect.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, out_data);
        errors++;
      end else begin
        want = mix_expect.pop_front();
        if (out_data.out_left !== want.out_left || out_data.out_right !== want.out_right ||
            out_data.button_busy !== want.button_busy ||
            out_data.slide_busy !== want.slide_busy ||
            out_data.hold_busy !== want.hold_busy) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_item_t it;
    int n;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    cfg_write(CFG_BUTTON_LEN, 14'd3);
    cfg_write(CFG_SLIDE_LEN, 14'd2);
    cfg_write(CFG_HOLD_LEN, 14'd4);
    it = rand_item(FUNC_WRITE);
    it.clip_select = 2'b11;
    send(it);
    it = rand_item(FUNC_WRITE);
    it.func = 3'b110;
    send(it);
    it = rand_item(FUNC_WRITE);
    it.func = 3'b111;
    send(it);
    mix(32767, -32768);
    for (int a = 0; a < 3; a++) wr_clip(SEL_BUTTON, a, 32767, -32768);
    wr_clip(SEL_SLIDE, 0, 32767, -32768);
    wr_clip(SEL_HOLD, 0, -32768, 32767);
    queue_item(rand_item(FUNC_TRIG_B));
    queue_item(rand_item(FUNC_TRIG_S));
    start(0);
    start(2);
    mix(32767, -32768);
    mix(-32768, 32767);
    mix(0, 0);
    mix(-1, 1);
    queue_item(rand_item(FUNC_STOP));
    mix(100, -100);
    start(24'hFFFFFF);
    mix(5, 5);
    mix(-5, -5);
    settle();

    for (int p = 0; p < 12; p++) begin
      calm = (p % 4 == 1);
      for (int i = 0; i < 3; i++) begin
        case (p)
          3: n = 16383;
          4: n = (i == 0) ? 8192 : (i == 1) ? 8191 : 1;
          5: n = 0;
          default: n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
        endcase
        cfg_write(2'(i), 14'(n));
      end
      for (int k = 0; k < 125; k++) random_item();
      settle();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
